[src/sdsc_pkg.sv]
package sdsc_pkg;

  // Parameter channel codes
  localparam logic [31:0] PREQ_IDLE     = 32'h0300_0000;
  localparam logic [31:0] PREQ_READ_ERR = 32'h1305_0080;
  localparam logic [31:0] PREQ_READ_WRN = 32'h1309_0080;
  localparam logic [7:0]  PCODE_READ_REPLY = 8'h13;
  localparam logic [15:0] PIDX_DIAG        = 16'd128;
  localparam logic [7:0]  PSUB_LAST_ERR    = 8'd5;
  localparam logic [7:0]  PSUB_LAST_WRN    = 8'd9;

  // Control word fixed bits and bit positions
  localparam logic [15:0] CW_BASE = 16'h0023;
  localparam int unsigned CW_TOGGLE   = 7;
  localparam int unsigned CW_DISABLE  = 8;
  localparam int unsigned CW_ENABLE   = 9;
  localparam int unsigned CW_QSTOP    = 10;
  localparam int unsigned CW_FRESET   = 11;
  localparam int unsigned CW_HALT     = 13;
  localparam int unsigned CW_CLRHALT  = 14;

  // Command bit positions
  localparam int unsigned CMD_DISABLE = 0;
  localparam int unsigned CMD_ENABLE  = 1;
  localparam int unsigned CMD_HALT    = 2;
  localparam int unsigned CMD_CLRHALT = 3;
  localparam int unsigned CMD_FRESET  = 4;
  localparam int unsigned CMD_QSTOP   = 5;

  // Drive state codes
  localparam logic [3:0] DSTATE_UNKNOWN  = 4'd0;
  localparam logic [3:0] DSTATE_START    = 4'd1;
  localparam logic [3:0] DSTATE_ON       = 4'd5;
  localparam logic [3:0] DSTATE_ENABLED  = 4'd6;
  localparam logic [3:0] DSTATE_QSTOP    = 4'd7;
  localparam logic [3:0] DSTATE_FAULT    = 4'd9;

  // Raw operating mode values and dense codes
  localparam logic [4:0] RAW_MODE_POS  = 5'h01;
  localparam logic [4:0] RAW_MODE_VEL  = 5'h03;
  localparam logic [4:0] RAW_MODE_TRQ  = 5'h04;
  localparam logic [4:0] RAW_MODE_HOME = 5'h06;
  localparam logic [4:0] RAW_MODE_SEQ  = 5'h1D;
  localparam logic [4:0] RAW_MODE_GEAR = 5'h1E;
  localparam logic [4:0] RAW_MODE_JOG  = 5'h1F;

  localparam logic [2:0] MODE_UNKNOWN = 3'd0;
  localparam logic [2:0] MODE_POS     = 3'd1;
  localparam logic [2:0] MODE_VEL     = 3'd2;
  localparam logic [2:0] MODE_TRQ     = 3'd3;
  localparam logic [2:0] MODE_HOME    = 3'd4;
  localparam logic [2:0] MODE_SEQ     = 3'd5;
  localparam logic [2:0] MODE_GEAR    = 3'd6;
  localparam logic [2:0] MODE_JOG     = 3'd7;

  typedef struct packed {
    logic [31:0]        param_ctrl_in;
    logic [31:0]        param_value_in;
    logic [15:0]        drive_status;
    logic [15:0]        mode_status;
    logic [15:0]        motion_status;
    logic [5:0]         command_bits;
    logic               velocity_write;
    logic signed [31:0] velocity_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        control_word;
    logic [31:0]        param_ctrl_out;
    logic signed [31:0] ref_velocity;
    logic [3:0]         drive_state;
    logic               power_stage_on;
    logic [7:0]         status_flags;
    logic [2:0]         mode_code;
    logic [6:0]         mode_flags;
    logic [10:0]        motion_flags;
    logic [15:0]        last_error;
    logic [15:0]        last_warning;
  } out_item_t;

  // Values that carry over from one transaction to the next
  typedef struct packed {
    logic [31:0] requested_velocity;
    logic [31:0] executed_velocity;
    logic [15:0] error_code;
    logic [15:0] warning_code;
  } sdsc_state_t;

endpackage

[src/sdsc_if.sv]
interface sdsc_in_if import sdsc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sdsc_out_if import sdsc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[src/sdsc_step.sv]
module sdsc_step import sdsc_pkg::*; (
  input  in_item_t    item,
  input  sdsc_state_t state,
  output out_item_t   result,
  output sdsc_state_t state_nxt
);

  logic [7:0]  pcode;
  logic [7:0]  psub;
  logic [15:0] pidx;
  logic        diag_reply;
  logic [15:0] err_cap;
  logic [15:0] wrn_cap;
  logic [3:0]  st;
  logic [3:0]  dstate;
  logic        power;
  logic        err_flag;
  logic        wrn_flag;
  logic        terminated;
  logic        err_keep;
  logic [2:0]  mcode;
  logic        toggle;
  logic        take_vel;
  logic [31:0] req_vel;
  logic [5:0]  cmd;
  logic        zero_cmd;
  logic [15:0] cw;
  logic [31:0] preq;

  // Parameter reply capture
  always_comb begin
    pcode      = item.param_ctrl_in[31:24];
    psub       = item.param_ctrl_in[23:16];
    pidx       = item.param_ctrl_in[15:0];
    diag_reply = (pcode == PCODE_READ_REPLY) && (pidx == PIDX_DIAG);
    err_cap    = (diag_reply && psub == PSUB_LAST_ERR) ?
                 item.param_value_in[15:0] : state.error_code;
    wrn_cap    = (diag_reply && psub == PSUB_LAST_WRN) ?
                 item.param_value_in[15:0] : state.warning_code;
  end

  // Drive state and status flags
  always_comb begin
    st         = item.drive_status[3:0];
    dstate     = (st >= DSTATE_START && st <= DSTATE_FAULT) ? st : DSTATE_UNKNOWN;
    err_flag   = item.drive_status[6];
    wrn_flag   = item.drive_status[7];
    terminated = item.drive_status[14];
    err_keep   = (dstate == DSTATE_FAULT) || err_flag;
  end

  // Operating mode decode
  always_comb begin
    unique case (item.mode_status[4:0])
      RAW_MODE_POS:  mcode = MODE_POS;
      RAW_MODE_VEL:  mcode = MODE_VEL;
      RAW_MODE_TRQ:  mcode = MODE_TRQ;
      RAW_MODE_HOME: mcode = MODE_HOME;
      RAW_MODE_SEQ:  mcode = MODE_SEQ;
      RAW_MODE_GEAR: mcode = MODE_GEAR;
      RAW_MODE_JOG:  mcode = MODE_JOG;
      default:       mcode = MODE_UNKNOWN;
    endcase
  end

  // Commands, velocity request and control word
  always_comb begin
    cmd      = item.command_bits;
    zero_cmd = cmd[CMD_DISABLE] | cmd[CMD_ENABLE] | cmd[CMD_HALT] | cmd[CMD_QSTOP];
    req_vel  = item.velocity_write ? item.velocity_value : state.requested_velocity;
    if (zero_cmd) begin
      req_vel = '0;
    end
    // disable wins over enable
    power = (st == DSTATE_ON) || (st == DSTATE_ENABLED) || (st == DSTATE_QSTOP) ||
            (cmd[CMD_ENABLE] && !cmd[CMD_DISABLE]);

    // velocity mode flips the toggle only when a new set point must be taken
    take_vel = (terminated && req_vel != '0) || (req_vel != state.executed_velocity);
    if (mcode != MODE_VEL) begin
      toggle = !item.mode_status[7];
    end else begin
      toggle = item.mode_status[7] ^ take_vel;
    end

    cw             = CW_BASE;
    cw[CW_TOGGLE]  = toggle;
    cw[CW_DISABLE] = cmd[CMD_DISABLE];
    cw[CW_ENABLE]  = power;
    cw[CW_QSTOP]   = cmd[CMD_QSTOP];
    cw[CW_FRESET]  = cmd[CMD_FRESET];
    cw[CW_HALT]    = cmd[CMD_HALT];
    cw[CW_CLRHALT] = cmd[CMD_CLRHALT];
  end

  // Parameter request, warning read wins
  always_comb begin
    priority if (wrn_flag) begin
      preq = PREQ_READ_WRN;
    end else if (err_keep) begin
      preq = PREQ_READ_ERR;
    end else begin
      preq = PREQ_IDLE;
    end
  end

  // Next state
  always_comb begin
    state_nxt.requested_velocity = req_vel;
    state_nxt.executed_velocity  = (mcode == MODE_VEL && take_vel) ?
                                   req_vel : state.executed_velocity;
    state_nxt.error_code         = err_keep ? err_cap : 16'd0;
    state_nxt.warning_code       = wrn_flag ? wrn_cap : 16'd0;
  end

  // Result assembly
  always_comb begin
    result.control_word   = cw;
    result.param_ctrl_out = preq;
    result.ref_velocity   = req_vel;
    result.drive_state    = dstate;
    result.power_stage_on = power;
    result.status_flags   = {item.drive_status[15:13], item.drive_status[10:6]};
    result.mode_code      = mcode;
    result.mode_flags     = {item.mode_status[11:8], item.mode_status[7:5]};
    result.motion_flags   = {item.motion_status[14:6], item.motion_status[1:0]};
    result.last_error     = state_nxt.error_code;
    result.last_warning   = state_nxt.warning_code;
  end

endmodule

[src/servo_drive_status_control_cycle_core.sv]
// Channel  Role    Handshake     Payload
// in_ch    sink    valid/ready   in_item_t  (status words, commands, velocity)
// out_ch   source  valid/ready   out_item_t (control word, request, decodes)
//
// Two register stages: input register, then result register. An accepted
// transaction moves on into the result register once that register is free
// or being emptied; one transaction per cycle sustained while out_ch.ready is high.
// The carried state (velocities, error and warning codes) updates as a
// transaction moves from the input register into the result register.
// Synchronous active-low reset clears the valid bits and the carried state.
// A stalled output holds the result; the input register keeps filling until
// both stages are full, then in_ch.ready drops.
module servo_drive_status_control_cycle_core import sdsc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  sdsc_in_if.sink         in_ch,
  sdsc_out_if.source      out_ch
);

  logic        s1_valid_r;
  in_item_t    s1_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  sdsc_state_t state_r;
  sdsc_state_t state_nxt;
  out_item_t   result;
  logic        advance;

  // Result register free or being emptied this cycle
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;

  sdsc_step u_step (
    .item      (s1_item_r),
    .state     (state_r),
    .result    (result),
    .state_nxt (state_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r <= in_ch.payload;
    end
  end

  // Result register and carried state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_item_r <= result;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  // Carried state only moves with a transaction
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && s1_valid_r) |=> $stable(state_r))
    else $error("state changed without a transaction");

  // An empty result stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

  // Fixed control word bits present on every result
  a_cw_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_item_r.control_word & CW_BASE) == CW_BASE))
    else $error("control word fixed bits missing");

  // Warning code cleared unless the drive reports a warning
  a_warn_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_valid_r && !s1_item_r.drive_status[7]) |=>
      (state_r.warning_code == 16'd0))
    else $error("warning code kept without warning flag");

endmodule
